FILE: rtl/gmp_pkg.sv
// Shared types and constants for the greedy multi-way partition core.
`timescale 1ns / 1ps
`default_nettype none
package gmp_pkg;

  localparam int SUM_BITS    = 56;
  localparam int CHOSEN_BITS = 4;
  localparam int CFG_BITS    = 5;

  // Per-cycle control from the selector to every cell.
  typedef struct packed {
    logic load;   // a word is accepted this cycle
    logic first;  // accepted word starts a new problem
    logic here;   // this cell holds the chosen subset
    logic after;  // this cell sits past the chosen one in the chain
  } cell_ctl_t;

  // Status a cell reports back.
  typedef struct packed {
    logic act;    // subset index is in use
    logic lt;     // cell key orders before the new key
  } cell_stat_t;

endpackage
`default_nettype wire

FILE: rtl/gmp_cell.sv
// One slot of the sorted chain of subset sums: holds a (sum, index) key.
`timescale 1ns / 1ps
`default_nettype none
module gmp_cell #(
  parameter int IDX_BITS = 4,
  parameter int CELL_IDX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire gmp_pkg::cell_ctl_t           ctl,
  input  wire logic [IDX_BITS:0]            limit,
  input  wire logic [gmp_pkg::SUM_BITS-1:0] key_sum,
  input  wire logic [IDX_BITS-1:0]          key_idx,
  input  wire logic [gmp_pkg::SUM_BITS-1:0] up_sum,
  input  wire logic [IDX_BITS-1:0]          up_idx,
  input  wire logic                         up_lt,
  output logic      [gmp_pkg::SUM_BITS-1:0] sum_e,
  output logic      [IDX_BITS-1:0]          idx_e,
  output gmp_pkg::cell_stat_t               stat
);
  import gmp_pkg::*;

  logic [SUM_BITS-1:0] sum;
  logic [IDX_BITS-1:0] idx;
  logic [SUM_BITS-1:0] sum_next;
  logic [IDX_BITS-1:0] idx_next;

  // a new problem sees the cleared, index-ordered chain
  assign sum_e = ctl.first ? '0 : sum;
  assign idx_e = ctl.first ? IDX_BITS'(CELL_IDX) : idx;

  assign stat.act = {1'b0, idx_e} < limit;
  assign stat.lt  = (sum_e < key_sum) || ((sum_e == key_sum) && (idx_e < key_idx));

  always_comb begin
    sum_next = sum_e;
    idx_next = idx_e;
    if (ctl.here || ctl.after) begin
      if (up_lt) begin
        sum_next = up_sum;
        idx_next = up_idx;
      end else if (ctl.here || stat.lt) begin
        sum_next = key_sum;
        idx_next = key_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      idx <= IDX_BITS'(CELL_IDX);
    end else if (ctl.load) begin
      sum <= sum_next;
      idx <= idx_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/greedy_multiway_partition_core.sv
// Top level: greedy multi-way partition over a sorted chain of subset cells.
// Each taken word's result is registered in the output register or the skid stage.
// Throughput: one word per cycle while item_stall is low; the chain re-sorts on accept.
// Output register plus one skid stage; item_stall rises only when the skid is full.
// Reset (rst, synchronous): all sums zero, running max zero, num_sets 2, outputs empty.
`timescale 1ns / 1ps
`default_nettype none
module greedy_multiway_partition_core #(
  parameter int MAX_SETS   = 16,
  parameter int VALUE_BITS = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gmp_pkg::CFG_BITS-1:0]     num_sets,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [VALUE_BITS-1:0]            item_value,
  input  wire logic                             first_item,
  input  wire logic                             last_item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic      [gmp_pkg::CHOSEN_BITS-1:0]  chosen_set,
  output logic      [gmp_pkg::SUM_BITS-1:0]     largest_sum,
  output logic                                  is_final
);
  import gmp_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_SETS);
  localparam int LIM_BITS = IDX_BITS + 1;

  logic [LIM_BITS-1:0] set_limit;
  logic [SUM_BITS-1:0] running_max;

  logic                accept;
  logic                take;
  logic                skid_valid;
  logic [CHOSEN_BITS-1:0] skid_chosen;
  logic [SUM_BITS-1:0] skid_sum;
  logic                skid_final;

  logic [SUM_BITS-1:0] cell_sum [MAX_SETS];
  logic [IDX_BITS-1:0] cell_idx [MAX_SETS];
  cell_stat_t          cell_stat [MAX_SETS];
  cell_ctl_t           cell_ctl [MAX_SETS];
  logic [MAX_SETS-1:0] act;
  logic [MAX_SETS-1:0] ge;
  logic [MAX_SETS-1:0] sel;

  logic [SUM_BITS-1:0] min_sum;
  logic [IDX_BITS-1:0] min_idx;
  logic [SUM_BITS:0]   raw_sum;
  logic [SUM_BITS-1:0] key_sum;
  logic [SUM_BITS-1:0] max_e;
  logic [SUM_BITS-1:0] new_max;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid & ~item_stall;
  assign take       = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_limit <= LIM_BITS'(2);
    end else if (cfg_valid && cfg_ready) begin
      if (num_sets < CFG_BITS'(2)) begin
        set_limit <= LIM_BITS'(2);
      end else if (int'(num_sets) > MAX_SETS) begin
        set_limit <= LIM_BITS'(MAX_SETS);
      end else begin
        set_limit <= LIM_BITS'(num_sets);
      end
    end
  end

  // first in-use cell along the chain holds the smallest active key
  for (genvar j = 0; j < MAX_SETS; j++) begin : g_sel
    assign act[j] = cell_stat[j].act;
    assign ge[j]  = |act[j:0];
    if (j == 0) begin : g_head
      assign sel[j] = act[j];
    end else begin : g_body
      assign sel[j] = act[j] & ~ge[j-1];
    end
    assign cell_ctl[j].load  = accept;
    assign cell_ctl[j].first = first_item;
    assign cell_ctl[j].here  = sel[j];
    assign cell_ctl[j].after = ge[j] & ~sel[j];
  end

  always_comb begin
    min_sum = '0;
    min_idx = '0;
    for (int j = 0; j < MAX_SETS; j++) begin
      min_sum = min_sum | ({SUM_BITS{sel[j]}} & cell_sum[j]);
      min_idx = min_idx | ({IDX_BITS{sel[j]}} & cell_idx[j]);
    end
  end

  assign raw_sum = {1'b0, min_sum} + (SUM_BITS + 1)'(item_value);
  assign key_sum = raw_sum[SUM_BITS] ? '1 : raw_sum[SUM_BITS-1:0];
  assign max_e   = first_item ? '0 : running_max;
  assign new_max = (key_sum > max_e) ? key_sum : max_e;

  for (genvar j = 0; j < MAX_SETS; j++) begin : g_cell
    logic [SUM_BITS-1:0] up_sum;
    logic [IDX_BITS-1:0] up_idx;
    logic                up_lt;
    if (j == MAX_SETS - 1) begin : g_tail
      assign up_sum = '0;
      assign up_idx = '0;
      assign up_lt  = 1'b0;
    end else begin : g_link
      assign up_sum = cell_sum[j+1];
      assign up_idx = cell_idx[j+1];
      assign up_lt  = cell_stat[j+1].lt;
    end
    gmp_cell #(
      .IDX_BITS (IDX_BITS),
      .CELL_IDX (j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl[j]),
      .limit   (set_limit),
      .key_sum (key_sum),
      .key_idx (min_idx),
      .up_sum  (up_sum),
      .up_idx  (up_idx),
      .up_lt   (up_lt),
      .sum_e   (cell_sum[j]),
      .idx_e   (cell_idx[j]),
      .stat    (cell_stat[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (accept) begin
      running_max <= new_max;
    end
  end

  // output word register with one skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (!result_valid || take) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
          chosen_set   <= skid_chosen;
          largest_sum  <= skid_sum;
          is_final     <= skid_final;
        end else begin
          result_valid <= accept;
          chosen_set   <= CHOSEN_BITS'(min_idx);
          largest_sum  <= new_max;
          is_final     <= last_item;
        end
      end else if (accept) begin
        skid_valid  <= 1'b1;
        skid_chosen <= CHOSEN_BITS'(min_idx);
        skid_sum    <= new_max;
        skid_final  <= last_item;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid word held without an output word");

  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted word produced no result word");

  a_one_choice: assert property (@(posedge clk) disable iff (rst)
    accept |-> $onehot(sel))
    else $error("subset choice not unique");

  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !first_item) |=> (running_max >= $past(running_max)))
    else $error("running maximum decreased within a problem");
`endif

endmodule
`default_nettype wire
